[rtl/sdspi_pkg.sv]
package sdspi_pkg;

    // Command sequence phases, one-hot.
    typedef enum logic [8:0] {
        PH_IDLE  = 9'b0_0000_0001,
        PH_DUMMY = 9'b0_0000_0010,
        PH_READY = 9'b0_0000_0100,
        PH_CMD   = 9'b0_0000_1000,
        PH_R1    = 9'b0_0001_0000,
        PH_EXTRA = 9'b0_0010_0000,
        PH_TAIL1 = 9'b0_0100_0000,
        PH_TAIL2 = 9'b0_1000_0000,
        PH_TOUT  = 9'b1_0000_0000
    } phase_t;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_RX    = 1'b1;

    localparam logic CFG_READY_TRIES = 1'b0;
    localparam logic CFG_RESP_TRIES  = 1'b1;

    localparam logic [1:0] KIND_R1   = 2'd0;
    localparam logic [1:0] KIND_R2   = 2'd1;
    localparam logic [1:0] KIND_R3R7 = 2'd2;
    localparam logic [1:0] KIND_DATA = 2'd3;

    localparam logic [7:0] IDLE_BYTE    = 8'hFF;
    localparam logic [7:0] CMD_PREFIX   = 8'h40;
    localparam logic [7:0] CRC_CMD0     = 8'h95;
    localparam logic [7:0] CRC_CMD8     = 8'h87;
    localparam logic [7:0] CRC_DEFAULT  = 8'h01;
    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_SEND_IF  = 6'd8;
    localparam logic [7:0] READY_TRIES_RESET = 8'd20;
    localparam logic [7:0] RESP_TRIES_RESET  = 8'd8;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    // One result word.
    typedef struct packed {
        logic        timed_out;
        logic [31:0] resp_data;
        logic [7:0]  r1_status;
        logic        done_res;
        logic        select_active;
        logic [7:0]  tx_byte;
        logic        tx_valid;
    } result_t;

endpackage

[rtl/sdspi_seq.sv]
module sdspi_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              req_type,
    input  logic [5:0]        cmd_index,
    input  logic [31:0]       cmd_arg,
    input  logic [1:0]        resp_kind,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        ready_tries,
    input  logic [7:0]        resp_tries,
    output sdspi_pkg::result_t result
);
    import sdspi_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  try_reg, try_next;
    logic [2:0]  count_reg, count_next;
    logic [5:0]  cmd_reg, cmd_next;
    logic [31:0] arg_reg, arg_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  r1_reg, r1_next;
    logic [31:0] resp_reg, resp_next;

    logic [7:0]  try_inc;
    logic [2:0]  extra_cnt;
    logic [2:0]  count_inc;
    logic [7:0]  cmd_byte;
    logic [7:0]  crc_byte;

    always_comb
    begin
        try_inc   = (try_reg != 8'hFF) ? (try_reg + 8'd1) : try_reg;
        count_inc = count_reg + 3'd1;

        case (kind_reg)
            KIND_R2:   extra_cnt = 3'd1;
            KIND_R3R7: extra_cnt = 3'd4;
            default:   extra_cnt = 3'd0;
        endcase

        if (cmd_reg == CMD_GO_IDLE) crc_byte = CRC_CMD0;
        else if (cmd_reg == CMD_SEND_IF) crc_byte = CRC_CMD8;
        else crc_byte = CRC_DEFAULT;

        case (count_reg)
            3'd1:    cmd_byte = arg_reg[31:24];
            3'd2:    cmd_byte = arg_reg[23:16];
            3'd3:    cmd_byte = arg_reg[15:8];
            3'd4:    cmd_byte = arg_reg[7:0];
            default: cmd_byte = crc_byte;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        try_next   = try_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        arg_next   = arg_reg;
        kind_next  = kind_reg;
        r1_next    = r1_reg;
        resp_next  = resp_reg;

        result               = '0;
        result.tx_valid      = 1'b1;
        result.tx_byte       = IDLE_BYTE;
        result.select_active = 1'b1;

        if (req_type == REQ_START)
        begin
            cmd_next   = cmd_index;
            arg_next   = cmd_arg;
            kind_next  = resp_kind;
            r1_next    = IDLE_BYTE;
            resp_next  = '0;
            try_next   = '0;
            count_next = '0;
            phase_next = PH_DUMMY;
            result.select_active = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_DUMMY:
                begin
                    try_next   = '0;
                    phase_next = PH_READY;
                end
                PH_READY:
                begin
                    if (rx_byte == IDLE_BYTE)
                    begin
                        count_next     = 3'd1;
                        phase_next     = PH_CMD;
                        result.tx_byte = CMD_PREFIX | {2'b00, cmd_reg};
                    end
                    else
                    begin
                        try_next = try_inc;
                        if (try_inc >= ready_tries)
                        begin
                            phase_next           = PH_TOUT;
                            result.select_active = 1'b0;
                        end
                    end
                end
                PH_CMD:
                begin
                    if (count_reg < 3'd6)
                    begin
                        result.tx_byte = cmd_byte;
                        count_next     = count_inc;
                    end
                    else
                    begin
                        try_next   = '0;
                        phase_next = PH_R1;
                    end
                end
                PH_R1:
                begin
                    if (rx_byte != IDLE_BYTE)
                    begin
                        r1_next    = rx_byte;
                        resp_next  = '0;
                        count_next = '0;
                        phase_next = (extra_cnt != 3'd0) ? PH_EXTRA : PH_TAIL1;
                    end
                    else
                    begin
                        try_next = try_inc;
                        if (try_inc >= resp_tries)
                        begin
                            phase_next           = PH_TOUT;
                            result.select_active = 1'b0;
                        end
                    end
                end
                PH_EXTRA:
                begin
                    // First received byte lands in the top lane.
                    case (count_reg)
                        3'd0:    resp_next = resp_reg | {rx_byte, 24'd0};
                        3'd1:    resp_next = resp_reg | {8'd0, rx_byte, 16'd0};
                        3'd2:    resp_next = resp_reg | {16'd0, rx_byte, 8'd0};
                        3'd3:    resp_next = resp_reg | {24'd0, rx_byte};
                        default: resp_next = resp_reg;
                    endcase
                    count_next = count_inc;
                    if (count_inc >= extra_cnt) phase_next = PH_TAIL1;
                end
                PH_TAIL1:
                begin
                    phase_next           = PH_TAIL2;
                    result.select_active = 1'b0;
                end
                PH_TAIL2:
                begin
                    phase_next       = PH_IDLE;
                    result           = '0;
                    result.done_res  = 1'b1;
                    result.r1_status = r1_reg;
                    result.resp_data = resp_reg;
                end
                PH_TOUT:
                begin
                    phase_next       = PH_IDLE;
                    r1_next          = IDLE_BYTE;
                    resp_next        = '0;
                    result           = '0;
                    result.done_res  = 1'b1;
                    result.r1_status = IDLE_BYTE;
                    result.timed_out = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    result     = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            try_reg   <= '0;
            count_reg <= '0;
            cmd_reg   <= '0;
            arg_reg   <= '0;
            kind_reg  <= '0;
            r1_reg    <= IDLE_BYTE;
            resp_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            try_reg   <= try_next;
            count_reg <= count_next;
            cmd_reg   <= cmd_next;
            arg_reg   <= arg_next;
            kind_reg  <= kind_next;
            r1_reg    <= r1_next;
            resp_reg  <= resp_next;
        end
    end

endmodule

[rtl/sd_spi_command_engine_top.sv]
// SD-card SPI-mode command sequencer. Send a start word (tuser = 0) with the
// command index, argument and response kind; each result word names the next
// byte to exchange on SPI and the chip-select level. Feed back the byte
// received in that exchange as a tuser = 1 word, until a result arrives with
// done_res set, carrying R1, the extra response bytes and the timeout flag.
// The block takes one word every cycle while tready is high and registers
// each result, updating the sequencer state once per accepted word. Its
// output register is backed by a one-word skid stage, so tready depends only
// on registers: during a downstream stall one more word is taken, then tready
// drops until the stall clears. The user must write the two retry limits
// via cfg port only while no command is in flight; the block doesn't enforce.
module sd_spi_command_engine_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // cmd_index[5:0], cmd_arg[37:6], resp_kind[39:38], rx_byte[47:40]
    input  logic [sdspi_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type[0]
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tx_valid[0], tx_byte[8:1], select_active[9], done_res[10],
    // r1_status[18:11], resp_data[50:19], timed_out[51], zero fill [55:52]
    output logic [sdspi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [7:0]                         cfg_data
);
    import sdspi_pkg::*;

    logic [7:0] ready_tries_reg;
    logic [7:0] resp_tries_reg;
    result_t    result;
    result_t    out_data_reg;
    result_t    skid_data_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    logic       accept;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_tries_reg <= READY_TRIES_RESET;
            resp_tries_reg  <= RESP_TRIES_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_READY_TRIES) ready_tries_reg <= cfg_data;
            else resp_tries_reg <= cfg_data;
        end
    end

    sdspi_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (s_axis_tuser),
        .cmd_index   (s_axis_tdata[5:0]),
        .cmd_arg     (s_axis_tdata[37:6]),
        .resp_kind   (s_axis_tdata[39:38]),
        .rx_byte     (s_axis_tdata[47:40]),
        .ready_tries (ready_tries_reg),
        .resp_tries  (resp_tries_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg) out_data_reg <= skid_data_reg;
            else if (accept) out_data_reg <= result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

endmodule
